@@ rtl/rmst_pkg.sv @@
`default_nettype none

package rmst_pkg;

    // Fixed field widths of the stream payload
    localparam int IDX_W    = 10;
    localparam int VAL_W    = 16;
    localparam int OUT_W    = 16;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    // Operation codes carried in the mode field
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Input item as packed on s_tdata (last member sits in the lowest bits)
    typedef struct packed {
        logic             spare;
        logic [IDX_W-1:0] range_high;
        logic [IDX_W-1:0] range_low;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             mode;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/rmst_node_ram.sv @@
`default_nettype none

module rmst_node_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] node_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/rmst_seq.sv @@
`default_nettype none

module rmst_seq #(
    parameter int INDEX_RANGE = 1024,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // item channel
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire rmst_pkg::item_t              item,
    // result channel
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [rmst_pkg::OUT_W-1:0]        res_data
);

    import rmst_pkg::*;

    localparam int NODE_COUNT = 2 * INDEX_RANGE;
    localparam int AW         = $clog2(NODE_COUNT);
    localparam int QW         = $clog2(NODE_COUNT + 1);
    localparam int EW         = (QW > IDX_W) ? QW : IDX_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_LEAF,
        ST_U_LEAF_WR,
        ST_U_SIB,
        ST_U_UP,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         node_reg, node_next;
    logic [VALUE_BITS-1:0] cur_reg, cur_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic                  pend_reg, pend_next;
    logic [QW-1:0]         lo_reg, lo_next;
    logic [QW-1:0]         hi_reg, hi_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic                  query_phase;
    logic [VALUE_BITS-1:0] max_a;
    logic [VALUE_BITS-1:0] max_y;
    logic [VALUE_BITS-1:0] best_m;
    logic [AW-1:0]         parent;
    logic [QW-1:0]         hi_dec;
    logic [EW-1:0]         idx_ext;
    logic [EW-1:0]         rl_ext;
    logic [EW-1:0]         rh_ext;
    logic [EW-1:0]         hi_sat;

    rmst_node_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (AW),
        .DATA_W (VALUE_BITS)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Shared max unit: running best for queries, carried node value for updates
    assign query_phase = (state_reg == ST_Q_LO) || (state_reg == ST_Q_HI);
    assign max_a       = query_phase ? best_reg : cur_reg;
    assign max_y       = (max_a > mem_rdata) ? max_a : mem_rdata;
    assign best_m      = pend_reg ? max_y : best_reg;

    assign parent  = node_reg >> 1;
    assign hi_dec  = hi_reg[0] ? (hi_reg - QW'(1)) : hi_reg;

    // Saturate the high end of a query range to the last leaf
    assign idx_ext = EW'(item.index);
    assign rl_ext  = EW'(item.range_low);
    assign rh_ext  = EW'(item.range_high);
    assign hi_sat  = (rh_ext >= EW'(INDEX_RANGE)) ? EW'(INDEX_RANGE - 1) : rh_ext;

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_Q_OUT);
    assign res_data   = OUT_W'(best_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        node_next  = node_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        pend_next  = pend_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mem_we     = 1'b0;
        mem_waddr  = node_reg;
        mem_wdata  = max_y;
        mem_raddr  = node_reg;

        case (state_reg)
            // sweep zeros through the node store after reset
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (node_reg == AW'(NODE_COUNT - 1)) begin
                    node_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    node_next = node_reg + AW'(1);
                end
            end

            ST_IDLE: begin
                if (item_valid) begin
                    if (item.mode == MODE_UPDATE) begin
                        // updates past the last leaf are dropped
                        if (idx_ext < EW'(INDEX_RANGE)) begin
                            node_next  = AW'(INDEX_RANGE) + AW'(item.index);
                            cur_next   = VALUE_BITS'(item.value);
                            state_next = ST_U_LEAF;
                        end
                    end else begin
                        best_next = '0;
                        pend_next = 1'b0;
                        if (rl_ext > hi_sat) begin
                            // empty range answers zero
                            state_next = ST_Q_OUT;
                        end else begin
                            lo_next    = QW'(rl_ext) + QW'(INDEX_RANGE);
                            hi_next    = QW'(hi_sat) + QW'(INDEX_RANGE) + QW'(1);
                            state_next = ST_Q_LO;
                        end
                    end
                end
            end

            ST_U_LEAF: begin
                state_next = ST_U_LEAF_WR;
            end

            ST_U_LEAF_WR: begin
                mem_we     = 1'b1;
                cur_next   = max_y;
                state_next = ST_U_SIB;
            end

            ST_U_SIB: begin
                mem_raddr  = {node_reg[AW-1:1], ~node_reg[0]};
                state_next = ST_U_UP;
            end

            // parent = max(this node, its sibling)
            ST_U_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                cur_next  = max_y;
                node_next = parent;
                if (parent == AW'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_U_SIB;
                end
            end

            // left edge of the window
            ST_Q_LO: begin
                best_next = best_m;
                pend_next = 1'b0;
                if (lo_reg >= hi_reg) begin
                    state_next = ST_Q_OUT;
                end else begin
                    if (lo_reg[0]) begin
                        mem_raddr = AW'(lo_reg);
                        pend_next = 1'b1;
                        lo_next   = lo_reg + QW'(1);
                    end
                    state_next = ST_Q_HI;
                end
            end

            // right edge of the window, then climb one level
            ST_Q_HI: begin
                best_next = best_m;
                pend_next = 1'b0;
                if (hi_reg[0]) begin
                    mem_raddr = AW'(hi_dec);
                    pend_next = 1'b1;
                end
                lo_next    = lo_reg >> 1;
                hi_next    = hi_dec >> 1;
                state_next = ST_Q_LO;
            end

            ST_Q_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            node_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            node_reg  <= node_next;
            pend_reg  <= pend_next;
        end
        cur_reg  <= cur_next;
        best_reg <= best_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
    end

endmodule

`default_nettype wire

@@ rtl/range_max_segment_tree.sv @@
// Update: merges the value into its leaf, then climbs one tree level at a time to the root.
// Query: climbs from the leaves toward the root, two window edges per level.
// One item at a time; the node memory (one write, one read port) and the shared max unit set the rate.
// Results sit in an output register, so a new item is taken while a result waits.
// aresetn is synchronous, active low; after it the block clears 2*INDEX_RANGE nodes,
// one per cycle, and accepts no transfer until that pass is done.
`default_nettype none

module range_max_segment_tree #(
    parameter int INDEX_RANGE = 1024,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // mode[0], index[10:1], value[26:11], range_low[36:27], range_high[46:37], zero[47]
    input  wire logic [rmst_pkg::S_DATA_W-1:0]  s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // max_found[15:0]
    output logic      [rmst_pkg::M_DATA_W-1:0]  m_tdata
);

    import rmst_pkg::*;

    item_t               in_item;
    logic                res_valid;
    logic                res_ready;
    logic [OUT_W-1:0]    res_data;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign in_item = item_t'(s_tdata);

    rmst_seq #(
        .INDEX_RANGE (INDEX_RANGE),
        .VALUE_BITS  (VALUE_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (in_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tdata_reg <= M_DATA_W'(res_data);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ tb/range_max_checker.sv @@
`timescale 1ns / 100ps

// Watches both stream channels, keeps its own copy of the max tree and
// compares every result transfer against the oldest predicted maximum.
module range_max_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [rmst_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [rmst_pkg::M_DATA_W-1:0]   m_tdata,
    output int                                   mismatches,
    output int                                   pending
);

    import rmst_pkg::*;

    localparam int LEAVES = 1 << IDX_W;

    // node 1 is the root, leaf i sits at node LEAVES+i
    logic [VAL_W-1:0] tree_max [1:2*LEAVES-1];
    // maxima predicted for queries not yet answered, oldest first
    logic [OUT_W-1:0] max_due [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // merge a value into one leaf and refresh its ancestors
    task automatic raise_leaf(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        int p;
        p = LEAVES + idx;
        if (val > tree_max[p])
            tree_max[p] = val;
        p = p >> 1;
        while (p >= 1) begin
            tree_max[p] = (tree_max[2*p] > tree_max[2*p+1]) ? tree_max[2*p] : tree_max[2*p+1];
            p = p >> 1;
        end
    endtask

    // bottom-up walk over the inclusive range; an empty range gives zero
    function automatic logic [OUT_W-1:0] range_max(input int lo_idx, input int hi_idx);
        logic [VAL_W-1:0] best;
        int lo;
        int hi;
        best = '0;
        if (hi_idx >= LEAVES)
            hi_idx = LEAVES - 1;
        if (lo_idx > hi_idx)
            return '0;
        lo = lo_idx + LEAVES;
        hi = hi_idx + LEAVES + 1;
        while (lo < hi) begin
            if (lo[0]) begin
                if (tree_max[lo] > best)
                    best = tree_max[lo];
                lo++;
            end
            if (hi[0]) begin
                hi--;
                if (tree_max[hi] > best)
                    best = tree_max[hi];
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        return OUT_W'(best);
    endfunction

    // results are checked before the input transfer of the same edge is taken in
    always @(posedge aclk) begin : watch
        item_t            arrive;
        logic [OUT_W-1:0] due;
        if (!aresetn) begin
            for (int n = 1; n < 2*LEAVES; n++)
                tree_max[n] = '0;
            max_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (max_due.size() == 0) begin
                    report_mismatch($sformatf("result 0x%04h with no query waiting", m_tdata));
                end else begin
                    due = max_due.pop_front();
                    if (m_tdata !== due)
                        report_mismatch($sformatf("max_found 0x%04h, predicted 0x%04h",
                                                  m_tdata, due));
                end
            end
            if (s_tvalid && s_tready) begin
                arrive = s_tdata;
                if (arrive.mode == MODE_UPDATE)
                    raise_leaf(arrive.index, arrive.value);
                else
                    max_due.insert(max_due.size(),
                                   range_max(arrive.range_low, arrive.range_high));
            end
        end
        pending <= max_due.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import rmst_pkg::*;

    localparam int RANDOM_ITEMS = 1225;
    localparam int HOLD_START   = 4000;   // receiver hold-off window, in cycles
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_START   = 15000;  // receiver never idles in this window
    localparam int CALM_END     = 20000;
    localparam int DRAIN_CYCLES = 64;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    int                   fail_count;
    int                   due_count;
    bit                   gaps_on  = 1'b1;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    range_max_segment_tree DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    range_max_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (fail_count),
        .pending    (due_count)
    );

    // unused range fields carry random bits
    function automatic item_t update_item(input int idx, input int val);
        item_t it;
        it.spare      = 1'b0;
        it.mode       = MODE_UPDATE;
        it.index      = IDX_W'(idx);
        it.value      = VAL_W'(val);
        it.range_low  = IDX_W'($urandom);
        it.range_high = IDX_W'($urandom);
        return it;
    endfunction

    // unused index and value fields carry random bits
    function automatic item_t query_item(input int lo, input int hi);
        item_t it;
        it.spare      = 1'b0;
        it.mode       = MODE_QUERY;
        it.index      = IDX_W'($urandom);
        it.value      = VAL_W'($urandom);
        it.range_low  = IDX_W'(lo);
        it.range_high = IDX_W'(hi);
        return it;
    endfunction

    // optional idle cycles, then hold the item until the transfer happens
    task automatic send_item(input item_t it);
        while (gaps_on && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // leaves at both ends and in the middle, empty ranges, a lower value on a leaf
    task automatic run_directed();
        send_item(query_item(0, 1023));
        send_item(update_item(0, 1));
        send_item(update_item(1023, 16'hFFFF));
        send_item(update_item(512, 16'h8000));
        send_item(update_item(513, 0));
        send_item(update_item(512, 16'h7FFF));
        send_item(query_item(0, 0));
        send_item(query_item(1023, 1023));
        send_item(query_item(0, 1022));
        send_item(query_item(1, 511));
        send_item(query_item(513, 1022));
        send_item(query_item(1023, 0));
        send_item(query_item(600, 599));
        send_item(query_item(512, 512));
        send_item(update_item(1, 16'h5555));
        send_item(update_item(2, 16'hAAAA));
        send_item(query_item(1, 2));
        send_item(query_item(1, 1));
        send_item(query_item(2, 1023));
        send_item(query_item(0, 1023));
    endtask

    // indices lean toward both ends now and then so hot leaves get merged repeatedly
    function automatic int pick_index();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 31);
            2, 3:    return $urandom_range(992, 1023);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    task automatic run_random();
        int lo;
        int hi;
        int val;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = !(n >= 500 && n < 700);
            if (n == 900) begin
                // let every outstanding query be answered before going on
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (due_count != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 99) < 45) begin
                // value magnitude varies so maxima stay interesting
                val = $urandom_range(0, (1 << $urandom_range(1, 16)) - 1);
                send_item(update_item(pick_index(), val));
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        lo = $urandom_range(1, 1023);
                        hi = $urandom_range(0, lo - 1);
                    end
                    1: begin
                        lo = pick_index();
                        hi = lo;
                    end
                    2, 3, 4: begin
                        lo = pick_index();
                        hi = lo + $urandom_range(0, 15);
                        if (hi > 1023)
                            hi = 1023;
                    end
                    5: begin
                        lo = 0;
                        hi = $urandom_range(0, 1023);
                    end
                    6: begin
                        lo = $urandom_range(0, 1023);
                        hi = 1023;
                    end
                    default: begin
                        lo = $urandom_range(0, 1023);
                        hi = $urandom_range(lo, 1023);
                    end
                endcase
                send_item(query_item(lo, hi));
            end
        end
    endtask

    // receiver: random idling, one long hold-off, one window with no idling
    initial begin : result_ready
        int cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else if (cyc >= CALM_START && cyc < CALM_END)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 13);
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
